// File: rtl/core/adl_pkg.sv
// shared types and constants for the adler-32 checksum unit
`timescale 1ns / 1ps

package adl_pkg;

    localparam int unsigned DATA_W  = 64;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned HALF_W  = 16;
    localparam int unsigned WT_W    = 12;
    // widest high-sum intermediate for up to eight lanes
    localparam int unsigned ACC_W   = 20;

    localparam logic [HALF_W:0] ADLER_MOD = 17'd65521;
    // 2^16 mod 65521
    localparam logic [4:0]      FOLD_K    = 5'd15;

    typedef struct packed {
        logic [7:0]      lane_byte;
        logic [WT_W-1:0] wt_val;
    } t_lane_out;

endpackage

// File: rtl/core/adl_lane.sv
// one byte lane: masks the byte by the count and weights it for the high sum
`timescale 1ns / 1ps

module adl_lane
    import adl_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic [7:0]       i_byte,
    input  logic [CNT_W-1:0] i_count,
    output t_lane_out        o_lane
);

    logic             lane_on;
    logic [CNT_W-1:0] weight;

    assign lane_on = (CNT_W'(IDX) < i_count);
    // byte at position idx is counted (count - idx) times in the high sum
    assign weight  = i_count - CNT_W'(IDX);

    always_comb begin
        if (lane_on) begin
            o_lane.lane_byte = i_byte;
            o_lane.wt_val    = WT_W'(i_byte) * WT_W'(weight);
        end else begin
            o_lane.lane_byte = '0;
            o_lane.wt_val    = '0;
        end
    end

endmodule

// File: rtl/core/adl_merge.sv
// merging adder tree: totals the byte sum and the weighted sum over all lanes
`timescale 1ns / 1ps

module adl_merge
    import adl_pkg::*;
#(
    parameter int LANES  = 8,
    parameter int SUM_W  = 11,
    parameter int WSUM_W = 14
) (
    input  t_lane_out         i_lanes [LANES],
    output logic [SUM_W-1:0]  o_sum,
    output logic [WSUM_W-1:0] o_wsum
);

    always_comb begin
        logic [SUM_W-1:0]  acc_s;
        logic [WSUM_W-1:0] acc_w;
        acc_s = '0;
        acc_w = '0;
        for (int k = 0; k < LANES; k++) begin
            acc_s = acc_s + SUM_W'(i_lanes[k].lane_byte);
            acc_w = acc_w + WSUM_W'(i_lanes[k].wt_val);
        end
        o_sum  = acc_s;
        o_wsum = acc_w;
    end

endmodule

// File: rtl/core/adler32_checksum_unit.sv
// top level of the streaming adler-32 checksum unit
`timescale 1ns / 1ps

// Streaming Adler-32 engine taking up to LANES bytes per request, low byte first.
// It sustains one request per clock when not stalled: the byte lanes and the merging
// adder tree run in the first stage, and the second stage folds the lane totals into
// the running sums (low-sum add with one modular correction, count times low sum
// multiply, and a fold of the high sum). The feedback loop through the sum registers
// sets the rate. A checksum is registered and shown on o_valid once its last request
// leaves the stage-1 register, and is held in an output register, so requests keep
// flowing while it waits; the input stalls only when a second last request reaches
// the accumulator while the previous checksum is still not taken.
module adler32_checksum_unit
    import adl_pkg::*;
#(
    parameter int LANES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [DATA_W-1:0] i_data,
    input  logic [CNT_W-1:0]  i_valid_bytes,
    input  logic              i_first,
    input  logic              i_last,
    input  logic [31:0]       i_seed,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [31:0]       o_checksum
);

    localparam int SUM_W  = $clog2(LANES * 255 + 1);
    localparam int WSUM_W = $clog2(255 * LANES * (LANES + 1) / 2 + 1);

    // ---------------- stage 1: lanes and merge ----------------
    logic [CNT_W-1:0]  count_sat;
    t_lane_out         w_lane [LANES];
    logic [SUM_W-1:0]  w_sum;
    logic [WSUM_W-1:0] w_wsum;

    assign count_sat = (i_valid_bytes > CNT_W'(LANES)) ? CNT_W'(LANES) : i_valid_bytes;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        adl_lane #(
            .IDX(g)
        ) u_lane (
            .i_byte  (i_data[8*g +: 8]),
            .i_count (count_sat),
            .o_lane  (w_lane[g])
        );
    end

    adl_merge #(
        .LANES  (LANES),
        .SUM_W  (SUM_W),
        .WSUM_W (WSUM_W)
    ) u_merge (
        .i_lanes (w_lane),
        .o_sum   (w_sum),
        .o_wsum  (w_wsum)
    );

    logic              r_s1_valid;
    logic              r_s1_first;
    logic              r_s1_last;
    logic [31:0]       r_s1_seed;
    logic [CNT_W-1:0]  r_s1_count;
    logic [SUM_W-1:0]  r_s1_sum;
    logic [WSUM_W-1:0] r_s1_wsum;

    logic              r_out_valid;
    logic [31:0]       r_checksum;
    logic [HALF_W-1:0] r_sum_low;
    logic [HALF_W-1:0] r_sum_high;

    logic out_free;
    logic s2_fire;
    logic in_fire;

    assign out_free = !r_out_valid || !i_stall;
    assign s2_fire  = r_s1_valid && (!r_s1_last || out_free);
    assign o_stall  = r_s1_valid && !s2_fire;
    assign in_fire  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s2_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_first <= i_first;
            r_s1_last  <= i_last;
            r_s1_seed  <= i_seed;
            r_s1_count <= count_sat;
            r_s1_sum   <= w_sum;
            r_s1_wsum  <= w_wsum;
        end
    end

    // ---------------- stage 2: accumulate and reduce ----------------
    logic [HALF_W-1:0] a_base;
    logic [HALF_W-1:0] b_base;
    logic [HALF_W:0]   a_raw;
    logic [HALF_W-1:0] n_sum_low;
    logic [ACC_W-1:0]  b_raw;
    logic [HALF_W:0]   b_fold;
    logic [HALF_W-1:0] n_sum_high;

    assign a_base = r_s1_first ? r_s1_seed[15:0]  : r_sum_low;
    assign b_base = r_s1_first ? r_s1_seed[31:16] : r_sum_high;

    assign a_raw     = (HALF_W+1)'(a_base) + (HALF_W+1)'(r_s1_sum);
    assign n_sum_low = (a_raw >= ADLER_MOD) ? HALF_W'(a_raw - ADLER_MOD) : a_raw[HALF_W-1:0];

    assign b_raw = ACC_W'(b_base) + ACC_W'(ACC_W'(r_s1_count) * ACC_W'(a_base))
                 + ACC_W'(r_s1_wsum);
    // fold the bits above 16 back in, using 2^16 = 15 mod 65521
    assign b_fold = (HALF_W+1)'(b_raw[HALF_W-1:0])
                  + (HALF_W+1)'(b_raw[ACC_W-1:HALF_W] * FOLD_K);
    assign n_sum_high = (b_fold >= ADLER_MOD) ? HALF_W'(b_fold - ADLER_MOD)
                                              : b_fold[HALF_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_low  <= 16'd1;
            r_sum_high <= 16'd0;
        end else if (s2_fire) begin
            r_sum_low  <= n_sum_low;
            r_sum_high <= n_sum_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_fire && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire && r_s1_last) begin
            r_checksum <= {n_sum_high, n_sum_low};
        end
    end

    assign o_valid    = r_out_valid;
    assign o_checksum = r_checksum;

    // ---------------- assertions ----------------
    a_sums_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (17'(r_sum_low) < ADLER_MOD) && (17'(r_sum_high) < ADLER_MOD))
        else $error("running sums not reduced");

    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_s1_valid && r_s1_last))
        else $error("checksum without a last request");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid && r_s1_last && r_out_valid && i_stall)
        else $error("input stalled without a blocked checksum");

endmodule
